FILE: design/jfnr_pkg.sv
// ----------------------------------------------------------------------------
// jfnr_pkg
// Shared types and constants of the Jacobi four-neighbour relaxation unit.
// ----------------------------------------------------------------------------
package jfnr_pkg;

  // command codes of an input transaction
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_GRID_SIDE   = 1'd0;
  localparam logic [0:0] REG_SWEEP_COUNT = 1'd1;

  localparam logic [8:0] GRID_SIDE_RESET   = 9'd10;
  localparam logic [7:0] SWEEP_COUNT_RESET = 8'd38;
  localparam int         MIN_SIDE          = 3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [15:0] value;
  } req_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic               status;
  } rsp_t;

  typedef struct packed {
    logic [0:0] index;
    logic [8:0] wdata;
  } cfg_t;

endpackage

FILE: design/jfnr_chan_if.sv
// ----------------------------------------------------------------------------
// jfnr_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface jfnr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/jfnr_ram.sv
// ----------------------------------------------------------------------------
// jfnr_ram
// Grid bank: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jfnr_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/jacobi_four_neighbour_relaxation_unit.sv
// ----------------------------------------------------------------------------
// jacobi_four_neighbour_relaxation_unit
// Square grid of samples in two banks, relaxed by a five-point Jacobi stencil.
// ----------------------------------------------------------------------------
// A write command stores one cell of the current bank and answers in the next
// cycle; a read command answers after the bank read and the response register.
// A run command performs sweep_count sweeps; every sweep reads the current
// bank through its single read port, one neighbour per cycle into a shared
// accumulator, and writes the other bank: a border cell is copied, an interior
// cell gets the sum of its four neighbours shifted right by two. The unit takes
// no command during a read or a run. The banks are not cleared: the user must
// write every cell before use; the unit itself does not enforce it.
// ----------------------------------------------------------------------------
module jacobi_four_neighbour_relaxation_unit #(
  parameter int MAX_SIDE    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jfnr_chan_if.sink   req_i,
  jfnr_chan_if.source rsp_o,
  jfnr_chan_if.sink   cfg_i
);

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > 9) ? SIDE_W : 9;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int ACC_W  = SAMPLE_BITS + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CELL} state_e;
  typedef enum logic [2:0] {STEP_LEFT, STEP_RIGHT, STEP_UP, STEP_DOWN, STEP_LAST} step_e;

  state_e                   state_q, state_d;
  step_e                    step_q, step_d;
  logic [IDX_W-1:0]         r_q, r_d, c_q, c_d;
  logic [7:0]               k_q, k_d;
  logic                     cur_q, cur_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     rsp_valid_q, rsp_valid_d;
  jfnr_pkg::rsp_t           rsp_q, rsp_d;
  logic [8:0]               grid_side_q;
  logic [7:0]               sweep_count_q;

  logic [CMP_W-1:0]         eff_side, last_idx, side_lim, gs_ext;
  logic                     oob, border, req_fire;
  logic [IDX_W-1:0]         req_row, req_col;
  logic [ADDR_W-1:0]        raddr, waddr;
  logic [SAMPLE_BITS-1:0]   wdata, rd_a, rd_b, rd_cur;
  logic                     host_we, sweep_we, we_a, we_b;
  logic signed [ACC_W-1:0]  rd_ext, acc_base, acc_sum;

  // effective side, saturated to the supported range
  assign gs_ext   = CMP_W'(grid_side_q);
  assign side_lim = CMP_W'(MAX_SIDE);
  assign eff_side = (gs_ext < CMP_W'(jfnr_pkg::MIN_SIDE)) ? CMP_W'(jfnr_pkg::MIN_SIDE) :
                    (gs_ext > side_lim) ? side_lim : gs_ext;
  assign last_idx = eff_side - CMP_W'(1);

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_row  = IDX_W'(req_i.data.row);
  assign req_col  = IDX_W'(req_i.data.col);
  assign oob      = (CMP_W'(req_i.data.row) >= eff_side) ||
                    (CMP_W'(req_i.data.col) >= eff_side);

  assign border = (r_q == '0) || (c_q == '0) ||
                  (CMP_W'(r_q) == last_idx) || (CMP_W'(c_q) == last_idx);

  assign rd_cur   = cur_q ? rd_b : rd_a;
  assign rd_ext   = ACC_W'($signed(rd_cur));
  // shared adder of the stencil
  assign acc_base = (step_q == STEP_RIGHT) ? '0 : acc_q;
  assign acc_sum  = acc_base + rd_ext;

  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    host_we     = 1'b0;
    sweep_we    = 1'b0;
    raddr       = {req_row, req_col};
    waddr       = {r_q, c_q};
    wdata       = rd_cur;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          rsp_d.read_value = '0;
          rsp_d.status     = 1'b0;
          case (req_i.data.cmd)
            jfnr_pkg::CMD_WRITE: begin
              waddr        = {req_row, req_col};
              wdata        = SAMPLE_BITS'($unsigned(req_i.data.value));
              host_we      = !oob;
              rsp_d.status = oob;
              rsp_valid_d  = 1'b1;
            end
            jfnr_pkg::CMD_RUN: begin
              if (sweep_count_q == '0) begin
                rsp_valid_d = 1'b1;
              end else begin
                state_d = ST_CELL;
                step_d  = STEP_LEFT;
                r_d     = '0;
                c_d     = '0;
                k_d     = '0;
              end
            end
            jfnr_pkg::CMD_READ: begin
              if (oob) begin
                rsp_d.status = 1'b1;
                rsp_valid_d  = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        rsp_d.read_value = 16'($signed(rd_cur));
        rsp_d.status     = 1'b0;
        rsp_valid_d      = 1'b1;
        state_d          = ST_IDLE;
      end

      ST_CELL: begin
        // neighbour read issued in this step
        case (step_q)
          STEP_LEFT:  raddr = border ? {r_q, c_q} : {r_q, c_q - IDX_W'(1)};
          STEP_RIGHT: raddr = {r_q, c_q + IDX_W'(1)};
          STEP_UP:    raddr = {r_q - IDX_W'(1), c_q};
          STEP_DOWN:  raddr = {r_q + IDX_W'(1), c_q};
          default:    raddr = {r_q, c_q};
        endcase

        if (step_q == STEP_LEFT) begin
          step_d = STEP_RIGHT;
        end else if (step_q == STEP_RIGHT && border) begin
          sweep_we = 1'b1;
          wdata    = rd_cur;
        end else if (step_q == STEP_LAST) begin
          sweep_we = 1'b1;
          wdata    = acc_sum[ACC_W-1:2];
        end else begin
          acc_d = acc_sum;
          case (step_q)
            STEP_RIGHT: step_d = STEP_UP;
            STEP_UP:    step_d = STEP_DOWN;
            default:    step_d = STEP_LAST;
          endcase
        end

        if (sweep_we) begin
          step_d = STEP_LEFT;
          if (CMP_W'(c_q) == last_idx) begin
            c_d = '0;
            if (CMP_W'(r_q) == last_idx) begin
              r_d   = '0;
              cur_d = ~cur_q;
              k_d   = k_q + 8'd1;
              if (k_d == sweep_count_q) begin
                rsp_d.read_value = '0;
                rsp_d.status     = 1'b0;
                rsp_valid_d      = 1'b1;
                state_d          = ST_IDLE;
              end
            end else begin
              r_d = r_q + IDX_W'(1);
            end
          end else begin
            c_d = c_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // host writes go to the current bank, sweep writes to the other one
  assign we_a = (host_we && !cur_q) || (sweep_we && cur_q);
  assign we_b = (host_we && cur_q) || (sweep_we && !cur_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= STEP_LEFT;
      r_q           <= '0;
      c_q           <= '0;
      k_q           <= '0;
      cur_q         <= 1'b0;
      acc_q         <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_q         <= '0;
      grid_side_q   <= jfnr_pkg::GRID_SIDE_RESET;
      sweep_count_q <= jfnr_pkg::SWEEP_COUNT_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      cur_q       <= cur_d;
      acc_q       <= acc_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.index)
          jfnr_pkg::REG_GRID_SIDE:   grid_side_q   <= cfg_i.data.wdata;
          jfnr_pkg::REG_SWEEP_COUNT: sweep_count_q <= cfg_i.data.wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  jfnr_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  jfnr_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

endmodule

FILE: tb/jfnr_grid_check.sv
// ----------------------------------------------------------------------------
// jfnr_grid_check
// Watches the command, response and register channels of the relaxation unit.
// Keeps its own two-bank copy of the grid, works out the response of every
// accepted command and compares it field by field with the responses in order.
// ----------------------------------------------------------------------------
module jfnr_grid_check
  import jfnr_pkg::*;
#(
  parameter int MAX_SIDE = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_data_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  cfg_t cfg_data_i,
  output int   fail_count_o,
  output int   pending_count_o,
  output int   checked_count_o
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;

  logic signed [15:0] grid_q [2][CELLS];
  logic               cur_bank_q;
  logic [8:0]         side_q;
  logic [7:0]         sweeps_q;
  rsp_t               awaited_rsp_q [$];
  rsp_t               predicted;
  rsp_t               oldest;

  function automatic int unsigned active_side();
    if (side_q < MIN_SIDE) return MIN_SIDE;
    if (side_q > MAX_SIDE) return MAX_SIDE;
    return 32'(side_q);
  endfunction

  // one sweep from the current bank into the other one, then swap
  task automatic relax_sweep(input int unsigned n);
    int unsigned p;
    int          sum;
    logic        src;
    logic        dst;
    src = cur_bank_q;
    dst = ~cur_bank_q;
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) begin
        p = r * MAX_SIDE + c;
        if (r == 0 || c == 0 || r == n - 1 || c == n - 1) begin
          grid_q[dst][p] = grid_q[src][p];
        end else begin
          sum = int'(grid_q[src][p - 1]) + int'(grid_q[src][p + 1])
              + int'(grid_q[src][p - MAX_SIDE]) + int'(grid_q[src][p + MAX_SIDE]);
          grid_q[dst][p] = 16'(sum >>> 2);
        end
      end
    end
    cur_bank_q = dst;
  endtask

  task automatic apply_command(input req_t item, output rsp_t result);
    int unsigned n;
    int unsigned p;
    n = active_side();
    p = int'(item.row) * MAX_SIDE + int'(item.col);
    result = '0;
    case (item.cmd)
      CMD_WRITE, CMD_READ: begin
        if (item.row >= n || item.col >= n) begin
          result.status = 1'b1;
        end else if (item.cmd == CMD_WRITE) begin
          grid_q[cur_bank_q][p] = item.value;
        end else begin
          result.read_value = grid_q[cur_bank_q][p];
        end
      end
      CMD_RUN: begin
        repeat (sweeps_q) relax_sweep(n);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q          = GRID_SIDE_RESET;
      sweeps_q        = SWEEP_COUNT_RESET;
      cur_bank_q      = 1'b0;
      awaited_rsp_q.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
      checked_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.index)
          REG_GRID_SIDE:   side_q = cfg_data_i.wdata;
          REG_SWEEP_COUNT: sweeps_q = cfg_data_i.wdata[7:0];
          default: ;
        endcase
      end
      // a command may be taken in the same cycle as an earlier response, so predict first
      if (req_valid_i && req_ready_i) begin
        apply_command(req_data_i, predicted);
        awaited_rsp_q.push_back(predicted);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: response with no command pending: read_value %0d status %0d",
                   $time, rsp_data_i.read_value, rsp_data_i.status);
        end else begin
          oldest = awaited_rsp_q.pop_front();
          checked_count_o++;
          if (rsp_data_i.read_value !== oldest.read_value) begin
            fail_count_o++;
            $display("%0t: read_value mismatch: expected %0d, got %0d",
                     $time, oldest.read_value, rsp_data_i.read_value);
          end
          if (rsp_data_i.status !== oldest.status) begin
            fail_count_o++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, oldest.status, rsp_data_i.status);
          end
        end
      end
      pending_count_o = awaited_rsp_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Jacobi four-neighbour relaxation unit.
// A directed part hits field extremes, flagged addresses, the unused command
// and side saturation; then random phases pick a side and a sweep count, fill
// the whole grid, run one or more times and read cells back. Large sides only
// scatter writes and read them back. Both sides of the handshake stall.
// ----------------------------------------------------------------------------
module tb_top;
  import jfnr_pkg::*;

  localparam int          MAX_SIDE    = 256;
  localparam int          ITEM_TARGET = 1050;
  localparam logic [1:0]  CMD_SPARE   = 2'd3;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_RARE} stall_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jfnr_chan_if #(.payload_t(req_t)) req_if ();
  jfnr_chan_if #(.payload_t(rsp_t)) rsp_if ();
  jfnr_chan_if #(.payload_t(cfg_t)) cfg_if ();

  int fail_count;
  int pending_count;
  int checked_count;

  jacobi_four_neighbour_relaxation_unit #(
    .MAX_SIDE    (MAX_SIDE),
    .SAMPLE_BITS (16)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  jfnr_grid_check #(
    .MAX_SIDE (MAX_SIDE)
  ) u_grid_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (req_if.valid),
    .req_ready_i     (req_if.ready),
    .req_data_i      (req_if.data),
    .rsp_valid_i     (rsp_if.valid),
    .rsp_ready_i     (rsp_if.ready),
    .rsp_data_i      (rsp_if.data),
    .cfg_valid_i     (cfg_if.valid),
    .cfg_ready_i     (cfg_if.ready),
    .cfg_data_i      (cfg_if.data),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .checked_count_o (checked_count)
  );

  always #5 clk = ~clk;

  // response side stalls on its own pattern, switching mode now and then
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  rsp_if.ready <= 1'b1;
      STALL_COIN:  rsp_if.ready <= 1'($urandom_range(0, 1));
      STALL_THIRD: rsp_if.ready <= (stall_tick % 3 == 0);
      default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  int          burst_left;
  int unsigned active_n;
  int unsigned active_sweeps;
  int          counted_items;
  int          n_writes;
  int          n_reads;
  int          n_runs;
  int          n_sweeps;
  int          n_flagged;
  int          n_phases;

  function automatic int unsigned clamp_side(input logic [8:0] side);
    if (side < MIN_SIDE) return MIN_SIDE;
    if (side > MAX_SIDE) return MAX_SIDE;
    return 32'(side);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one command transaction, sent in bursts with random gaps in between
  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] row,
                          input logic [7:0] col, input logic [15:0] value);
    req_t item;
    item.cmd   = cmd;
    item.row   = row;
    item.col   = col;
    item.value = value;
    @(negedge clk);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk); while (!req_if.ready);
    counted_items++;
    if (cmd == CMD_RUN) begin
      n_runs++;
      n_sweeps += active_sweeps;
    end else if ((cmd == CMD_WRITE || cmd == CMD_READ) && row < active_n && col < active_n) begin
      if (cmd == CMD_WRITE) n_writes++;
      else n_reads++;
    end else begin
      n_flagged++;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input logic [8:0] wdata);
    cfg_t w;
    w.index = index;
    w.wdata = wdata;
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(input logic [8:0] side, input logic [7:0] sweeps);
    settle();
    write_reg(REG_GRID_SIDE, side);
    // bit 8 of the sweep register write is ignored by the unit
    write_reg(REG_SWEEP_COUNT, {1'($urandom_range(0, 1)), sweeps});
    active_n      = clamp_side(side);
    active_sweeps = 32'(sweeps);
    n_phases++;
  endtask

  // occasional flagged address, unused command or stray read
  task automatic maybe_stray(input bit grid_full);
    logic [7:0] r;
    logic [7:0] c;
    if ($urandom_range(0, 5) != 0) return;
    r = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1: begin
        if (active_n < MAX_SIDE) begin
          c = 8'($urandom_range(active_n, 255));
          if ($urandom_range(0, 1)) begin
            c = r;
            r = 8'($urandom_range(active_n, 255));
          end
          send_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, r, c, rand_sample());
        end else begin
          send_cmd(CMD_SPARE, r, c, rand_sample());
        end
      end
      3: begin
        if (grid_full) send_cmd(CMD_READ, 8'($urandom_range(0, active_n - 1)),
                                8'($urandom_range(0, active_n - 1)), rand_sample());
        else send_cmd(CMD_SPARE, r, c, rand_sample());
      end
      default: send_cmd(CMD_SPARE, r, c, rand_sample());
    endcase
  endtask

  // fill the whole grid, then run and read back a few times
  task automatic relax_phase(input int runs);
    for (int r = 0; r < active_n; r++) begin
      for (int c = 0; c < active_n; c++) begin
        maybe_stray(1'b0);
        send_cmd(CMD_WRITE, 8'(r), 8'(c), rand_sample());
      end
    end
    repeat (runs) begin
      maybe_stray(1'b1);
      send_cmd(CMD_RUN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               rand_sample());
      repeat ($urandom_range(2, 6)) begin
        maybe_stray(1'b1);
        send_cmd(CMD_READ, 8'($urandom_range(0, active_n - 1)),
                 8'($urandom_range(0, active_n - 1)), rand_sample());
      end
    end
  endtask

  // large grids cannot be filled cheaply: scattered writes read back only
  task automatic scatter_phase();
    logic [7:0] rows [$];
    logic [7:0] cols [$];
    int         k;
    repeat ($urandom_range(8, 20)) begin
      rows.push_back(8'($urandom_range(0, active_n - 1)));
      cols.push_back(8'($urandom_range(0, active_n - 1)));
      maybe_stray(1'b0);
      send_cmd(CMD_WRITE, rows[$], cols[$], rand_sample());
    end
    repeat (rows.size()) begin
      k = $urandom_range(0, rows.size() - 1);
      maybe_stray(1'b0);
      send_cmd(CMD_READ, rows[k], cols[k], rand_sample());
    end
  endtask

  initial begin
    logic [8:0] side;
    logic [7:0] sweeps;
    int         runs;
    int         phase;

    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rsp_if.ready = 1'b0;
    burst_left   = 0;
    active_n     = clamp_side(GRID_SIDE_RESET);
    active_sweeps = 32'(SWEEP_COUNT_RESET);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // side below the minimum, one sweep, floor of a negative quarter
    configure(9'd0, 8'd1);
    send_cmd(CMD_WRITE, 8'd0, 8'd0, 16'h7FFF);
    send_cmd(CMD_WRITE, 8'd0, 8'd1, 16'hFFFF);
    send_cmd(CMD_WRITE, 8'd0, 8'd2, 16'h8000);
    send_cmd(CMD_WRITE, 8'd1, 8'd0, 16'h0000);
    send_cmd(CMD_WRITE, 8'd1, 8'd1, 16'h1234);
    send_cmd(CMD_WRITE, 8'd1, 8'd2, 16'h0000);
    send_cmd(CMD_WRITE, 8'd2, 8'd0, 16'h0000);
    send_cmd(CMD_WRITE, 8'd2, 8'd1, 16'h0000);
    send_cmd(CMD_WRITE, 8'd2, 8'd2, 16'h7FFF);
    send_cmd(CMD_READ, 8'd1, 8'd1, 16'h0000);
    send_cmd(CMD_RUN, 8'd0, 8'd0, 16'h0000);
    send_cmd(CMD_READ, 8'd1, 8'd1, 16'h0000);
    send_cmd(CMD_READ, 8'd0, 8'd0, 16'h0000);
    send_cmd(CMD_READ, 8'd0, 8'd2, 16'h0000);
    send_cmd(CMD_WRITE, 8'd3, 8'd0, 16'h5A5A);
    send_cmd(CMD_READ, 8'd0, 8'd255, 16'h0000);
    send_cmd(CMD_SPARE, 8'd255, 8'd255, 16'hFFFF);
    send_cmd(CMD_RUN, 8'd255, 8'd255, 16'hFFFF);

    // side above the maximum saturates, far corner cells
    configure(9'd511, 8'd0);
    send_cmd(CMD_WRITE, 8'd255, 8'd255, 16'h8000);
    send_cmd(CMD_READ, 8'd255, 8'd255, 16'h0000);
    send_cmd(CMD_WRITE, 8'd255, 8'd0, 16'h7FFF);
    send_cmd(CMD_READ, 8'd255, 8'd0, 16'h0000);

    phase = 0;
    while (counted_items < ITEM_TARGET) begin
      runs = $urandom_range(1, 3);
      case (phase)
        0: begin
          side   = 9'd4;
          sweeps = 8'd255;
          runs   = 1;
        end
        1: begin
          side   = 9'($urandom_range(0, 2));
          sweeps = 8'd0;
        end
        2: begin
          side   = 9'd256;
          sweeps = 8'($urandom_range(0, 255));
        end
        3: begin
          side   = 9'($urandom_range(257, 511));
          sweeps = 8'($urandom_range(0, 255));
        end
        default: begin
          case ($urandom_range(0, 15))
            0:       side = 9'($urandom_range(0, 3));
            1:       side = 9'($urandom_range(257, 511));
            2:       side = 9'd256;
            default: side = 9'($urandom_range(4, 12));
          endcase
          // long sweep counts only on small grids, once per phase
          if (clamp_side(side) <= 5 && $urandom_range(0, 7) == 0) begin
            sweeps = 8'($urandom_range(128, 255));
            runs   = 1;
          end else begin
            sweeps = 8'($urandom_range(0, 12));
          end
        end
      endcase
      configure(side, sweeps);
      if (active_n > 16) scatter_phase();
      else relax_phase(runs);
      phase++;
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d writes, %0d reads, %0d runs with %0d sweeps, %0d flagged or unused",
             n_writes, n_reads, n_runs, n_sweeps, n_flagged);
    $display("%0d register settings, %0d responses compared", n_phases, checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("timeout with %0d responses outstanding", pending_count);
    $display("Mismatches found");
    $finish;
  end

endmodule
